>>> rtl/core/pivc_pkg.sv
// shared constants and register indexes of the pi velocity controller
package pivc_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int GAIN_W         = 16;
    localparam int CFG_IDX_W      = 3;

    localparam int INT_SHIFT  = 16;
    localparam int PROP_SHIFT = 8;

    // bias ramp: 60.0 in q7.8, split as 15 * 2^10
    localparam int RAMP_END   = 15360;
    localparam int RAMP_HALF  = 7680;
    localparam int RAMP_W     = 14;
    localparam int RAMP_SHIFT = 10;
    localparam int RAMP_DIV   = 15;

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST = 16'd256;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_CONTROL_MODE    = 3'd0;
    localparam cfg_idx_t CFG_PROP_GAIN       = 3'd1;
    localparam cfg_idx_t CFG_INTEG_STEP_GAIN = 3'd2;
    localparam cfg_idx_t CFG_INTEG_UPPER     = 3'd3;
    localparam cfg_idx_t CFG_INTEG_LOWER     = 3'd4;
    localparam cfg_idx_t CFG_RAMP_BIAS       = 3'd5;

    localparam logic MODE_PI   = 1'b0;
    localparam logic MODE_BIAS = 1'b1;

endpackage

>>> rtl/core/pivc_in_if.sv
// velocity sample channel: measured and desired velocity
interface pivc_in_if #(
    parameter int DATA_WIDTH = pivc_pkg::DATA_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] measured_velocity;
    logic signed [DATA_WIDTH-1:0] desired_velocity;

    modport source (
        output valid,
        output measured_velocity,
        output desired_velocity,
        input  ready
    );

    modport sink (
        input  valid,
        input  measured_velocity,
        input  desired_velocity,
        output ready
    );
endinterface

>>> rtl/core/pivc_out_if.sv
// drive command channel: current command and integrator value
interface pivc_out_if #(
    parameter int DATA_WIDTH = pivc_pkg::DATA_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] current_command;
    logic signed [DATA_WIDTH-1:0] integrator_value;

    modport source (
        output valid,
        output current_command,
        output integrator_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  current_command,
        input  integrator_value,
        output ready
    );
endinterface

>>> rtl/core/pi_velocity_controller_with_bias_mode.sv
// PI velocity controller with integrator clamp and bias ramp mode, one command per tick while
// the drive side keeps taking them. Each velocity sample passes an input register, a product
// register that holds the gain and ramp multiplies, and the result register on its way to one
// drive command. The integrator add and clamp sit between the product and result registers,
// so a new sample is taken every cycle and throughput is one transaction per clock as long as
// the result side keeps taking them. In PI mode the command is prop_gain * error plus the
// trapezoidal integrator, clamped to integ_lower..integ_upper and saturated to DATA_WIDTH bits;
// in bias mode the command ramps from the ramp bias at zero velocity down to zero at 60.0 and
// the integrator and prior error hold. Configuration is written through cfg_wr_en, cfg_addr
// and cfg_wdata and should only change while no transaction is in flight.
module pi_velocity_controller_with_bias_mode #(
    parameter int DATA_WIDTH = pivc_pkg::DATA_WIDTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    pivc_in_if.sink                   velocity,
    pivc_out_if.source                drive,
    input  logic                      cfg_wr_en,
    input  pivc_pkg::cfg_idx_t        cfg_addr,
    input  logic [((DATA_WIDTH > pivc_pkg::GAIN_W) ? DATA_WIDTH : pivc_pkg::GAIN_W)-1:0]
                                      cfg_wdata
);
    import pivc_pkg::*;

    localparam int D     = DATA_WIDTH;
    localparam int BW    = D - 1;
    localparam int EW    = D + 1;
    localparam int SW    = D + 2;
    localparam int PIW   = SW + GAIN_W + 1;
    localparam int PPW   = EW + GAIN_W + 1;
    localparam int STEPW = PIW - INT_SHIFT;
    localparam int ACCW  = STEPW + 1;
    localparam int PRW   = PPW - PROP_SHIFT;
    localparam int SUMW  = PRW + 1;
    localparam int RPW   = BW + RAMP_W;
    localparam int YW    = RPW - RAMP_SHIFT;
    localparam int MW    = YW - 3;
    localparam longint unsigned RECIP_L = (longint'(1) << YW) / RAMP_DIV;
    localparam logic [MW-1:0] RECIP = MW'(RECIP_L);
    localparam logic signed [D-1:0] DMAX = {1'b0, {(D-1){1'b1}}};
    localparam logic signed [D-1:0] DMIN = {1'b1, {(D-1){1'b0}}};

    // configuration
    logic                       mode_reg;
    logic        [GAIN_W-1:0]   prop_gain_reg;
    logic        [GAIN_W-1:0]   integ_gain_reg;
    logic signed [D-1:0]        upper_reg;
    logic signed [D-1:0]        lower_reg;
    logic        [BW-1:0]       bias_reg;

    // controller state
    logic signed [EW-1:0]       prior_err_reg;
    logic signed [EW-1:0]       prior_err_next;
    logic signed [D-1:0]        integ_reg;
    logic signed [D-1:0]        integ_next;

    // input register
    logic                       s1_valid_reg;
    logic                       s1_mode_reg;
    logic signed [D-1:0]        s1_meas_reg;
    logic signed [D-1:0]        s1_des_reg;

    // product register
    logic                       s2_valid_reg;
    logic                       s2_mode_reg;
    logic signed [PIW-1:0]      s2_pint_reg;
    logic signed [PPW-1:0]      s2_pprop_reg;
    logic        [RPW-1:0]      s2_pramp_reg;
    logic                       s2_rzero_reg;
    logic                       s2_rbias_reg;

    // result register
    logic                       out_valid_reg;
    logic signed [D-1:0]        out_cmd_reg;
    logic signed [D-1:0]        out_integ_reg;
    logic signed [D-1:0]        cmd_next;

    logic                       out_free;
    logic                       s2_free;
    logic                       s2_adv;
    logic                       s1_adv;
    logic                       in_ready;
    logic                       in_accept;

    logic signed [EW-1:0]       err;
    logic signed [SW-1:0]       esum;
    logic signed [GAIN_W:0]     igain_s;
    logic signed [GAIN_W:0]     pgain_s;
    logic signed [PIW-1:0]      pint;
    logic signed [PPW-1:0]      pprop;
    logic        [RAMP_W-1:0]   ramp_w;
    logic        [RPW-1:0]      pramp;
    logic                       rzero;
    logic                       rbias;

    logic signed [PIW-1:0]      pint_rnd;
    logic signed [STEPW-1:0]    step;
    logic signed [ACCW-1:0]     acc;
    logic signed [D-1:0]        acc_clamped;
    logic signed [PPW-1:0]      pprop_rnd;
    logic signed [PRW-1:0]      prop;
    logic signed [SUMW-1:0]     pi_sum;
    logic signed [D-1:0]        pi_cmd;

    logic        [YW-1:0]       ramp_y;
    logic        [YW+MW-1:0]    ramp_prod;
    logic        [MW-1:0]       ramp_q0;
    logic        [MW+3:0]       ramp_q15;
    logic        [YW:0]         ramp_rem;
    logic        [MW-1:0]       ramp_q;
    logic signed [D-1:0]        ramp_cmd;

    // handshake
    assign out_free  = !out_valid_reg || drive.ready;
    assign s2_adv    = s2_valid_reg && out_free;
    assign s2_free   = !s2_valid_reg || out_free;
    assign s1_adv    = s1_valid_reg && s2_free;
    assign in_ready  = !s1_valid_reg || s2_free;
    assign in_accept = velocity.valid && in_ready;

    assign velocity.ready         = in_ready;
    assign drive.valid            = out_valid_reg;
    assign drive.current_command  = out_cmd_reg;
    assign drive.integrator_value = out_integ_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_PI;
            prop_gain_reg  <= PROP_GAIN_RST;
            integ_gain_reg <= '0;
            upper_reg      <= DMAX;
            lower_reg      <= DMIN;
            bias_reg       <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_CONTROL_MODE:    mode_reg       <= cfg_wdata[0];
                CFG_PROP_GAIN:       prop_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                CFG_INTEG_STEP_GAIN: integ_gain_reg <= cfg_wdata[GAIN_W-1:0];
                CFG_INTEG_UPPER:     upper_reg      <= cfg_wdata[D-1:0];
                CFG_INTEG_LOWER:     lower_reg      <= cfg_wdata[D-1:0];
                CFG_RAMP_BIAS:       bias_reg       <= cfg_wdata[BW-1:0];
                default:             ;
            endcase
        end
    end

    // stage one: error and multiplies
    always_comb
    begin
        err     = EW'(s1_des_reg) - EW'(s1_meas_reg);
        esum    = SW'(err) + SW'(prior_err_reg);
        igain_s = {1'b0, integ_gain_reg};
        pgain_s = {1'b0, prop_gain_reg};
        pint    = PIW'(esum) * PIW'(igain_s);
        pprop   = PPW'(err) * PPW'(pgain_s);
        rzero   = (int'(s1_meas_reg) > RAMP_END);
        rbias   = s1_meas_reg[D-1];
        ramp_w  = RAMP_W'(RAMP_END - int'(s1_meas_reg));
        pramp   = (RPW'(bias_reg) * RPW'(ramp_w)) + RPW'(RAMP_HALF);
    end

    always_comb
    begin
        prior_err_next = prior_err_reg;
        if (s1_adv && (s1_mode_reg == MODE_PI))
        begin
            prior_err_next = err;
        end
    end

    // stage two: rounding, integrator clamp, saturation, ramp divide
    always_comb
    begin
        pint_rnd = s2_pint_reg + PIW'(longint'(1) << (INT_SHIFT - 1));
        step     = STEPW'(pint_rnd >>> INT_SHIFT);
        acc      = ACCW'(integ_reg) + ACCW'(step);
        if (acc > ACCW'(upper_reg))
        begin
            acc_clamped = upper_reg;
        end
        else if (acc < ACCW'(lower_reg))
        begin
            acc_clamped = lower_reg;
        end
        else
        begin
            acc_clamped = acc[D-1:0];
        end

        pprop_rnd = s2_pprop_reg + PPW'(longint'(1) << (PROP_SHIFT - 1));
        prop      = PRW'(pprop_rnd >>> PROP_SHIFT);
        pi_sum    = SUMW'(prop) + SUMW'(acc_clamped);
        if (pi_sum > SUMW'(DMAX))
        begin
            pi_cmd = DMAX;
        end
        else if (pi_sum < SUMW'(DMIN))
        begin
            pi_cmd = DMIN;
        end
        else
        begin
            pi_cmd = pi_sum[D-1:0];
        end

        // divide by 15 through a reciprocal, then one correction step
        ramp_y    = s2_pramp_reg[RPW-1:RAMP_SHIFT];
        ramp_prod = (YW+MW)'(ramp_y) * (YW+MW)'(RECIP);
        ramp_q0   = ramp_prod[YW+MW-1:YW];
        ramp_q15  = {ramp_q0, 4'b0000} - (MW+4)'(ramp_q0);
        ramp_rem  = (YW+1)'(ramp_y) - (YW+1)'(ramp_q15);
        ramp_q    = ramp_q0 + MW'(ramp_rem[4:0] >= 5'(RAMP_DIV));
        if (s2_rzero_reg)
        begin
            ramp_cmd = '0;
        end
        else if (s2_rbias_reg)
        begin
            ramp_cmd = {1'b0, bias_reg};
        end
        else
        begin
            ramp_cmd = {1'b0, ramp_q[BW-1:0]};
        end

        if (s2_mode_reg == MODE_PI)
        begin
            cmd_next   = pi_cmd;
            integ_next = acc_clamped;
        end
        else
        begin
            cmd_next   = ramp_cmd;
            integ_next = integ_reg;
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prior_err_reg <= '0;
            integ_reg     <= '0;
        end
        else
        begin
            prior_err_reg <= prior_err_next;
            if (in_ready)
            begin
                s1_valid_reg <= velocity.valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
            if (s2_adv)
            begin
                integ_reg <= integ_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_mode_reg <= mode_reg;
            s1_meas_reg <= velocity.measured_velocity;
            s1_des_reg  <= velocity.desired_velocity;
        end
        if (s1_adv)
        begin
            s2_mode_reg  <= s1_mode_reg;
            s2_pint_reg  <= pint;
            s2_pprop_reg <= pprop;
            s2_pramp_reg <= pramp;
            s2_rzero_reg <= rzero;
            s2_rbias_reg <= rbias;
        end
        if (s2_adv)
        begin
            out_cmd_reg   <= cmd_next;
            out_integ_reg <= integ_next;
        end
    end

    // the reported integrator always tracks the live state
    a_integ_report: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_integ_reg == integ_reg))
        else $error("reported integrator differs from state");

    // bias mode leaves the integrator alone
    a_bias_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_adv && (s2_mode_reg == MODE_BIAS)) |=> $stable(integ_reg))
        else $error("integrator changed in bias mode");

    // integrator lands inside ordered clamp limits after a pi update
    a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_adv && (s2_mode_reg == MODE_PI) && (upper_reg >= lower_reg))
        |=> ((integ_reg <= $past(upper_reg)) && (integ_reg >= $past(lower_reg))))
        else $error("integrator outside clamp limits");

    // bias ramp command stays between zero and the bias
    a_ramp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_adv && (s2_mode_reg == MODE_BIAS))
        |=> ((out_cmd_reg >= 0) && (out_cmd_reg <= $signed({1'b0, $past(bias_reg)}))))
        else $error("bias ramp command out of range");

    // input side only stalls while the input, product and result registers are all occupied
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s2_valid_reg && out_valid_reg))
        else $error("input stalled with free pipeline slot");

endmodule
